// ----- rtl/core/ncsc_pkg.sv -----
// Shared types, constants and helpers for the command sentence checker.
`default_nettype none

package ncsc_pkg;

    localparam int HEADER_CHARS = 8;
    localparam int COUNTER_BITS = 16;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 8 * HEADER_CHARS;

    localparam int OUT_BITS = 80;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_HEADER_WORD   = 3'd0,
        CFG_HEADER_LENGTH = 3'd1,
        CFG_MIN_ID        = 3'd2,
        CFG_MAX_ID        = 3'd3,
        CFG_ID_POS        = 3'd4,
        CFG_VALUE_POS     = 3'd5
    } cfg_addr_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_HEADER      = 3'd1,
        ERR_NO_START    = 3'd2,
        ERR_NO_STOP     = 3'd3,
        ERR_NO_CHECKSUM = 3'd4,
        ERR_CHECKSUM    = 3'd5,
        ERR_ID_RANGE    = 3'd6
    } err_code_t;

    // Number field scanner state.
    typedef enum logic [1:0] {
        SCAN_LEAD = 2'd0,
        SCAN_NUM  = 2'd1,
        SCAN_DONE = 2'd2
    } scan_t;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    localparam logic [3:0] FIELD_MAX  = 4'd15;
    localparam logic [3:0] HPOS_MAX   = 4'd15;
    localparam logic [3:0] HEADER_MAX = 4'(HEADER_CHARS);

    localparam logic [31:0] VALUE_MAG_MAX = 32'h8000_0000;
    localparam logic [31:0] VALUE_POS_MAX = 32'h7FFF_FFFF;

    // Returns {is_hex, nibble}.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, 4'(c - CH_ZERO)};
        end
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            r = {1'b1, 4'(c - CH_UPPER_A + 8'd10)};
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            r = {1'b1, 4'(c - CH_LOWER_A + 8'd10)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nmea_command_sentence_checker.sv -----
// Command sentence checker: byte parser, checksum and field decoder with a result register.
//
// Sentence bytes enter on the s_ channel, one item per byte, with s_tlast on
// the final byte of a sentence. Each byte is first held in an input register
// and is parsed from there; the sentence's result goes into an
// output register and is offered on the m_ channel. Only the final byte of a
// sentence produces a result item; all other bytes produce none.
// Throughput: one byte per cycle while no last byte waits on a held result, set by
// the single parse stage between the input and output registers. Configuration must
// be written through cfg_wr_en, cfg_addr and cfg_wdata only while no sentence is in
// flight; the block itself does not enforce this.
// When the receiver stalls with a result waiting, the parse stage still takes
// bytes that produce no result; a last byte waits in the input register, and
// s_tready drops until the result is taken.
// Reset clears all sentence state, the counters and the last command value,
// and loads the documented configuration defaults.
`default_nettype none

module nmea_command_sentence_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [ncsc_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  wire logic [ncsc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,  // msg_byte
    input  wire logic                                s_tlast,  // end_of_message
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // sentence_ok[0], error_code[3:1], cmd_id[11:4], cmd_value[43:12],
    // valid_count[59:44], invalid_count[75:60], zero fill[79:76]
    output logic [ncsc_pkg::OUT_BITS-1:0]            m_tdata
);
    import ncsc_pkg::*;

    // Configuration.
    logic [CFG_DATA_BITS-1:0] header_word_reg;
    logic [3:0]               header_length_reg;
    logic [7:0]               min_id_reg;
    logic [7:0]               max_id_reg;
    logic [3:0]               id_pos_reg;
    logic [3:0]               value_pos_reg;

    // Input stage.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Sentence state.
    logic        past_comma_reg, past_comma_next;
    logic        started_reg, started_next;
    logic        stopped_reg, stopped_next;
    logic [7:0]  xor_reg, xor_next;
    logic [3:0]  hpos_reg, hpos_next;
    logic        hmatch_reg, hmatch_next;
    logic [3:0]  field_reg, field_next;
    scan_t       scan_reg, scan_next;
    logic [7:0]  id_acc_reg, id_acc_next;
    logic        id_invalid_reg, id_invalid_next;
    logic [31:0] val_acc_reg, val_acc_next;
    logic        val_neg_reg, val_neg_next;
    logic [7:0]  rsum_reg, rsum_next;
    logic [1:0]  sdc_reg, sdc_next;

    // Persistent results.
    logic [31:0]             last_value_reg, last_value_next;
    logic [COUNTER_BITS-1:0] valid_cnt_reg, valid_cnt_next;
    logic [COUNTER_BITS-1:0] invalid_cnt_reg, invalid_cnt_next;

    // Output stage.
    logic                out_valid_reg;
    logic [OUT_BITS-1:0] out_data_reg, out_data_next;

    logic       out_free;
    logic       consume;
    logic       emit;
    logic [3:0] hlimit;
    logic [7:0] c;
    logic [4:0] hex;
    logic       is_digit;
    logic       is_space;
    logic       is_id;
    logic       is_val;
    logic [11:0] id_mul;
    logic [35:0] val_mul;
    logic        hmatch_final;
    err_code_t   code;
    logic [31:0] value_out;

    assign out_free = !out_valid_reg || m_tready;
    assign consume  = in_valid_reg && (!in_last_reg || out_free);
    assign emit     = consume && in_last_reg;
    assign s_tready = !in_valid_reg || consume;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign hlimit   = (header_length_reg > HEADER_MAX) ? HEADER_MAX : header_length_reg;
    assign c        = in_byte_reg;
    assign hex      = hex_decode(c);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    assign is_id    = (field_reg == id_pos_reg);
    assign is_val   = (field_reg == value_pos_reg);
    assign id_mul   = {1'b0, id_acc_reg, 3'b000} + {3'b000, id_acc_reg, 1'b0}
                      + 12'(c - CH_ZERO);
    assign val_mul  = {1'b0, val_acc_reg, 3'b000} + {3'b000, val_acc_reg, 1'b0}
                      + 36'(c - CH_ZERO);

    // Per-byte parse step.
    always_comb
    begin
        past_comma_next = past_comma_reg;
        started_next    = started_reg;
        stopped_next    = stopped_reg;
        xor_next        = xor_reg;
        hpos_next       = hpos_reg;
        hmatch_next     = hmatch_reg;
        field_next      = field_reg;
        scan_next       = scan_reg;
        id_acc_next     = id_acc_reg;
        id_invalid_next = id_invalid_reg;
        val_acc_next    = val_acc_reg;
        val_neg_next    = val_neg_reg;
        rsum_next       = rsum_reg;
        sdc_next        = sdc_reg;

        if (stopped_reg) begin
            // Only the two checksum digits matter after the stop mark.
            if (sdc_reg < 2'd2) begin
                if (!hex[4]) begin
                    sdc_next = 2'd3;
                end
                else begin
                    rsum_next = {rsum_reg[3:0], hex[3:0]};
                    sdc_next  = sdc_reg + 2'd1;
                end
            end
        end
        else begin
            if (started_reg) begin
                if (c == CH_STAR) begin
                    stopped_next = 1'b1;
                end
                else begin
                    xor_next = xor_reg ^ c;
                end
            end
            else if (c == CH_DOLLAR) begin
                started_next = 1'b1;
            end

            if (!past_comma_reg) begin
                if (c == CH_COMMA) begin
                    if (hpos_reg < hlimit) begin
                        hmatch_next = 1'b0;
                    end
                    past_comma_next = 1'b1;
                    field_next      = 4'd1;
                    scan_next       = SCAN_LEAD;
                end
                else begin
                    if (hpos_reg < hlimit &&
                        header_word_reg[8*hpos_reg[2:0] +: 8] != c) begin
                        hmatch_next = 1'b0;
                    end
                    if (hpos_reg < HPOS_MAX) begin
                        hpos_next = hpos_reg + 4'd1;
                    end
                end
            end
            else if (!stopped_next) begin
                if (c == CH_COMMA) begin
                    if (field_reg < FIELD_MAX) begin
                        field_next = field_reg + 4'd1;
                    end
                    scan_next = SCAN_LEAD;
                end
                else if ((is_id || is_val) && scan_reg != SCAN_DONE) begin
                    if (scan_reg == SCAN_LEAD && is_space) begin
                        scan_next = scan_reg;
                    end
                    else if (scan_reg == SCAN_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
                        scan_next = SCAN_NUM;
                        if (c == CH_MINUS) begin
                            if (is_id) begin
                                id_invalid_next = 1'b1;
                            end
                            if (is_val) begin
                                val_neg_next = 1'b1;
                            end
                        end
                    end
                    else if (!is_digit) begin
                        scan_next = SCAN_DONE;
                    end
                    else begin
                        scan_next = SCAN_NUM;
                        if (is_id) begin
                            if (id_mul > 12'd255) begin
                                id_acc_next     = 8'd255;
                                id_invalid_next = 1'b1;
                            end
                            else begin
                                id_acc_next = id_mul[7:0];
                            end
                        end
                        if (is_val) begin
                            if (val_mul > 36'(VALUE_MAG_MAX)) begin
                                val_acc_next = VALUE_MAG_MAX;
                            end
                            else begin
                                val_acc_next = val_mul[31:0];
                            end
                        end
                    end
                end
            end
        end
    end

    // Sentence verdict, evaluated on the state after the last byte.
    always_comb
    begin
        hmatch_final = hmatch_next && !(hpos_next < hlimit && !past_comma_next);
        priority if (!hmatch_final) begin
            code = ERR_HEADER;
        end
        else if (!started_next) begin
            code = ERR_NO_START;
        end
        else if (!stopped_next) begin
            code = ERR_NO_STOP;
        end
        else if (sdc_next != 2'd2) begin
            code = ERR_NO_CHECKSUM;
        end
        else if (rsum_next != xor_next) begin
            code = ERR_CHECKSUM;
        end
        else if (id_invalid_reg || id_acc_reg < min_id_reg || id_acc_reg > max_id_reg) begin
            code = ERR_ID_RANGE;
        end
        else begin
            code = ERR_NONE;
        end
    end

    // An ok sentence ends inside its checksum, so the field registers already hold
    // their final values here.
    always_comb
    begin
        if (val_neg_reg) begin
            value_out = 32'd0 - val_acc_reg;
        end
        else if (val_acc_reg > VALUE_POS_MAX) begin
            value_out = VALUE_POS_MAX;
        end
        else begin
            value_out = val_acc_reg;
        end

        last_value_next  = last_value_reg;
        valid_cnt_next   = valid_cnt_reg;
        invalid_cnt_next = invalid_cnt_reg;
        if (emit) begin
            if (code == ERR_NONE) begin
                if (value_pos_reg != 4'd0 && field_reg >= value_pos_reg) begin
                    last_value_next = value_out;
                end
                valid_cnt_next = valid_cnt_reg + COUNTER_BITS'(1);
            end
            else if (code == ERR_ID_RANGE) begin
                valid_cnt_next   = valid_cnt_reg + COUNTER_BITS'(1);
                invalid_cnt_next = invalid_cnt_reg + COUNTER_BITS'(1);
            end
            else begin
                invalid_cnt_next = invalid_cnt_reg + COUNTER_BITS'(1);
            end
        end

        out_data_next = {4'd0,
                         16'(invalid_cnt_next),
                         16'(valid_cnt_next),
                         last_value_next,
                         (code == ERR_NONE) ? id_acc_reg : 8'd0,
                         code,
                         (code == ERR_NONE || code == ERR_ID_RANGE)};
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            header_word_reg   <= '0;
            header_length_reg <= 4'd1;
            min_id_reg        <= 8'd1;
            max_id_reg        <= 8'd255;
            id_pos_reg        <= 4'd1;
            value_pos_reg     <= 4'd2;
        end
        else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_HEADER_WORD:   header_word_reg   <= cfg_wdata;
                CFG_HEADER_LENGTH: header_length_reg <= cfg_wdata[3:0];
                CFG_MIN_ID:        min_id_reg        <= cfg_wdata[7:0];
                CFG_MAX_ID:        max_id_reg        <= cfg_wdata[7:0];
                CFG_ID_POS:        id_pos_reg        <= cfg_wdata[3:0];
                CFG_VALUE_POS:     value_pos_reg     <= cfg_wdata[3:0];
                default:           ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Sentence state; a finished sentence returns it to the idle values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            past_comma_reg  <= 1'b0;
            started_reg     <= 1'b0;
            stopped_reg     <= 1'b0;
            xor_reg         <= 8'd0;
            hpos_reg        <= 4'd0;
            hmatch_reg      <= 1'b1;
            field_reg       <= 4'd0;
            scan_reg        <= SCAN_LEAD;
            id_acc_reg      <= 8'd0;
            id_invalid_reg  <= 1'b0;
            val_acc_reg     <= 32'd0;
            val_neg_reg     <= 1'b0;
            rsum_reg        <= 8'd0;
            sdc_reg         <= 2'd0;
            last_value_reg  <= 32'd0;
            valid_cnt_reg   <= '0;
            invalid_cnt_reg <= '0;
        end
        else if (consume) begin
            last_value_reg  <= last_value_next;
            valid_cnt_reg   <= valid_cnt_next;
            invalid_cnt_reg <= invalid_cnt_next;
            if (in_last_reg) begin
                past_comma_reg  <= 1'b0;
                started_reg     <= 1'b0;
                stopped_reg     <= 1'b0;
                xor_reg         <= 8'd0;
                hpos_reg        <= 4'd0;
                hmatch_reg      <= 1'b1;
                field_reg       <= 4'd0;
                scan_reg        <= SCAN_LEAD;
                id_acc_reg      <= 8'd0;
                id_invalid_reg  <= 1'b0;
                val_acc_reg     <= 32'd0;
                val_neg_reg     <= 1'b0;
                rsum_reg        <= 8'd0;
                sdc_reg         <= 2'd0;
            end
            else begin
                past_comma_reg  <= past_comma_next;
                started_reg     <= started_next;
                stopped_reg     <= stopped_next;
                xor_reg         <= xor_next;
                hpos_reg        <= hpos_next;
                hmatch_reg      <= hmatch_next;
                field_reg       <= field_next;
                scan_reg        <= scan_next;
                id_acc_reg      <= id_acc_next;
                id_invalid_reg  <= id_invalid_next;
                val_acc_reg     <= val_acc_next;
                val_neg_reg     <= val_neg_next;
                rsum_reg        <= rsum_next;
                sdc_reg         <= sdc_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free) begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking testbench for the command sentence checker: directed and random sentences.
`timescale 1ns / 100ps

module testbench;

    import ncsc_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    typedef struct {
        logic        ok;
        err_code_t   code;
        logic [7:0]  id;
        logic [31:0] value;
        logic [15:0] good_cnt;
        logic [15:0] bad_cnt;
    } sentence_status_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    cfg_addr_t                 cfg_addr  = CFG_HEADER_WORD;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata   = 8'h00;  // msg_byte
    logic                      s_tlast   = 1'b0;   // end_of_message
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    // sentence_ok[0], error_code[3:1], cmd_id[11:4], cmd_value[43:12],
    // valid_count[59:44], invalid_count[75:60], zero fill[79:76]
    logic [OUT_BITS-1:0]       m_tdata;

    // Shadow of the configuration registers.
    logic [63:0] cfg_header    = 64'h0;
    logic [3:0]  cfg_hdr_len   = 4'd1;
    logic [7:0]  cfg_min_id    = 8'd1;
    logic [7:0]  cfg_max_id    = 8'd255;
    logic [3:0]  cfg_id_pos    = 4'd1;
    logic [3:0]  cfg_value_pos = 4'd2;

    // Sentence parse state of the predictor.
    logic        in_body;
    logic        seen_start;
    logic        seen_stop;
    logic [7:0]  body_xor;
    logic [7:0]  sum_field;
    logic        hdr_good;
    logic        id_bad;
    logic        val_neg;
    int          hdr_pos;
    int          field_idx;
    int          sum_digits;
    int          id_acc;
    longint      val_acc;
    scan_t       scan_state;
    logic [31:0] last_value = 32'd0;
    logic [15:0] good_count = 16'd0;
    logic [15:0] bad_count  = 16'd0;

    sentence_status_t awaited_status[$];

    int  mismatches  = 0;
    int  bytes_sent  = 0;
    int  hold_cycles = 0;
    int  stall_left  = 0;
    bit  tx_idle     = 1'b1;
    bit  rx_idle     = 1'b1;

    nmea_command_sentence_checker u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int header_span();
        return (cfg_hdr_len > HEADER_CHARS) ? HEADER_CHARS : int'(cfg_hdr_len);
    endfunction

    function automatic void clear_sentence_state();
        in_body    = 1'b0;
        seen_start = 1'b0;
        seen_stop  = 1'b0;
        body_xor   = 8'h00;
        sum_field  = 8'h00;
        hdr_good   = 1'b1;
        id_bad     = 1'b0;
        val_neg    = 1'b0;
        hdr_pos    = 0;
        field_idx  = 0;
        sum_digits = 0;
        id_acc     = 0;
        val_acc    = 0;
        scan_state = SCAN_LEAD;
    endfunction

    // Advances the parse state by one accepted sentence byte.
    function automatic void track_byte(input logic [7:0] c);
        int nib;
        bit is_id;
        bit is_val;
        nib = -1;
        if (seen_stop) begin
            if (sum_digits < 2) begin
                if (c >= CH_ZERO && c <= CH_NINE) nib = int'(c - CH_ZERO);
                else if (c >= CH_UPPER_A && c <= CH_UPPER_F) nib = int'(c - CH_UPPER_A) + 10;
                else if (c >= CH_LOWER_A && c <= CH_LOWER_F) nib = int'(c - CH_LOWER_A) + 10;
                if (nib < 0) begin
                    sum_digits = 3;
                end
                else begin
                    sum_field = {sum_field[3:0], 4'(nib)};
                    sum_digits++;
                end
            end
            return;
        end
        if (seen_start) begin
            if (c == CH_STAR) seen_stop = 1'b1;
            else body_xor ^= c;
        end
        else if (c == CH_DOLLAR) begin
            seen_start = 1'b1;
        end
        if (!in_body) begin
            if (c == CH_COMMA) begin
                if (hdr_pos < header_span()) hdr_good = 1'b0;
                in_body    = 1'b1;
                field_idx  = 1;
                scan_state = SCAN_LEAD;
            end
            else begin
                if (hdr_pos < header_span() && cfg_header[8*hdr_pos +: 8] != c) hdr_good = 1'b0;
                if (hdr_pos < 15) hdr_pos++;
            end
            return;
        end
        if (seen_stop) return;
        if (c == CH_COMMA) begin
            if (field_idx < 15) field_idx++;
            scan_state = SCAN_LEAD;
            return;
        end
        is_id  = (field_idx == cfg_id_pos);
        is_val = (field_idx == cfg_value_pos);
        if (!(is_id || is_val) || scan_state == SCAN_DONE) return;
        if (scan_state == SCAN_LEAD) begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
            if (c == CH_PLUS || c == CH_MINUS) begin
                scan_state = SCAN_NUM;
                if (c == CH_MINUS) begin
                    if (is_id) id_bad = 1'b1;
                    if (is_val) val_neg = 1'b1;
                end
                return;
            end
        end
        if (c < CH_ZERO || c > CH_NINE) begin
            scan_state = SCAN_DONE;
            return;
        end
        scan_state = SCAN_NUM;
        if (is_id) begin
            id_acc = id_acc * 10 + int'(c - CH_ZERO);
            if (id_acc > 255) begin
                id_acc = 255;
                id_bad = 1'b1;
            end
        end
        if (is_val) begin
            val_acc = val_acc * 10 + longint'(c - CH_ZERO);
            if (val_acc > longint'(VALUE_MAG_MAX)) val_acc = longint'(VALUE_MAG_MAX);
        end
    endfunction

    // Works out the status of a finished sentence and queues it.
    function automatic void close_sentence();
        sentence_status_t st;
        err_code_t code;
        if (hdr_pos < header_span() && !in_body) hdr_good = 1'b0;
        if (!hdr_good) code = ERR_HEADER;
        else if (!seen_start) code = ERR_NO_START;
        else if (!seen_stop) code = ERR_NO_STOP;
        else if (sum_digits != 2) code = ERR_NO_CHECKSUM;
        else if (sum_field != body_xor) code = ERR_CHECKSUM;
        else if (id_bad || id_acc < int'(cfg_min_id) || id_acc > int'(cfg_max_id))
            code = ERR_ID_RANGE;
        else code = ERR_NONE;

        st.id = 8'd0;
        if (code == ERR_NONE) begin
            st.id = 8'(id_acc);
            if (cfg_value_pos != 0 && field_idx >= cfg_value_pos) begin
                if (val_neg) last_value = 32'd0 - val_acc[31:0];
                else if (val_acc > longint'(VALUE_POS_MAX)) last_value = VALUE_POS_MAX;
                else last_value = val_acc[31:0];
            end
            good_count++;
        end
        else if (code == ERR_ID_RANGE) begin
            good_count++;
            bad_count++;
        end
        else begin
            bad_count++;
        end
        st.ok       = (code == ERR_NONE || code == ERR_ID_RANGE);
        st.code     = code;
        st.value    = last_value;
        st.good_cnt = good_count;
        st.bad_cnt  = bad_count;
        awaited_status.push_back(st);
        clear_sentence_state();
    endfunction

    function automatic void push_text(ref byte_q_t q, input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endfunction

    // Appends '*' and the two hex digits of the XOR between '$' and '*'.
    function automatic void seal(ref byte_q_t q, input bit lower);
        logic [7:0] sum;
        bit on;
        sum = 8'h00;
        on = 1'b0;
        for (int i = 0; i < q.size(); i++) begin
            if (!on) begin
                if (q[i] == CH_DOLLAR) on = 1'b1;
            end
            else if (q[i] == CH_STAR) begin
                break;
            end
            else begin
                sum ^= q[i];
            end
        end
        q.push_back(CH_STAR);
        push_text(q, $sformatf(lower ? "%02x" : "%02X", sum));
    endfunction

    function automatic void push_number(ref byte_q_t q, input longint v);
        longint mag;
        if ($urandom_range(0, 3) == 0)
            q.push_back(($urandom_range(0, 1) == 1) ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4)));
        // Now and then the field carries no digits at all.
        if ($urandom_range(0, 15) == 0) return;
        mag = (v < 0) ? -v : v;
        if (v < 0) q.push_back(CH_MINUS);
        else if ($urandom_range(0, 3) == 0) q.push_back(CH_PLUS);
        push_text(q, $sformatf("%0d", mag));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
        track_byte(b);
        if (last) close_sentence();
    endtask

    task automatic send_sentence(input byte_q_t q);
        for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
    endtask

    task automatic send_text(input string body, input bit add_sum, input string tail,
                             input bit lead_nul);
        byte_q_t q;
        if (lead_nul) q.push_back(8'h00);
        push_text(q, body);
        if (add_sum) seal(q, $urandom_range(0, 1));
        push_text(q, tail);
        send_sentence(q);
    endtask

    // Mostly well-formed sentences for the current setup, some damaged, a few pure noise.
    task automatic send_random_sentence();
        byte_q_t q;
        int pick;
        int nfields;
        int lim;
        int cut;
        longint idv;
        longint valv;
        longint mag;
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            repeat ($urandom_range(1, 16)) q.push_back(8'($urandom_range(0, 255)));
        end
        else begin
            lim = header_span();
            if (lim == 0) q.push_back(CH_DOLLAR);
            for (int i = 0; i < lim; i++) q.push_back(cfg_header[8*i +: 8]);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) q.push_back(8'(CH_UPPER_A + $urandom_range(0, 25)));

            case ($urandom_range(0, 9))
                0: idv = $urandom_range(256, 1200);
                1: idv = -longint'($urandom_range(0, 40));
                2, 3: idv = $urandom_range(0, 255);
                default: idv = $urandom_range(cfg_min_id, cfg_max_id);
            endcase
            case ($urandom_range(0, 7))
                0: mag = longint'($urandom) * $urandom_range(1, 40);
                1: mag = longint'(VALUE_POS_MAX) + $urandom_range(0, 2);
                default: mag = $urandom_range(0, 99999);
            endcase
            valv = ($urandom_range(0, 1) == 1) ? -mag : mag;

            nfields = (cfg_id_pos > cfg_value_pos) ? cfg_id_pos : cfg_value_pos;
            if (nfields == 0) nfields = 1;
            nfields += $urandom_range(0, 1);
            for (int f = 1; f <= nfields; f++) begin
                q.push_back(CH_COMMA);
                if (f == cfg_id_pos) push_number(q, idv);
                else if (f == cfg_value_pos) push_number(q, valv);
                else repeat ($urandom_range(0, 3)) q.push_back(8'(CH_LOWER_A + $urandom_range(0, 25)));
            end
            seal(q, $urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0) push_text(q, "\r\n");

            if (pick < 7) begin
                case ($urandom_range(0, 3))
                    0: q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
                    1: q.delete($urandom_range(0, q.size() - 1));
                    2:
                    begin
                        cut = $urandom_range(1, q.size());
                        while (q.size() > cut) void'(q.pop_back());
                    end
                    default: q.insert($urandom_range(0, q.size()), 8'($urandom_range(0, 255)));
                endcase
            end
        end
        send_sentence(q);
    endtask

    // Waits until every awaited status has come back and the pipeline is empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaited_status.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_addr_t which, input logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= which;
        cfg_wdata <= value;
        case (which)
            CFG_HEADER_WORD:   cfg_header    = value;
            CFG_HEADER_LENGTH: cfg_hdr_len   = value[3:0];
            CFG_MIN_ID:        cfg_min_id    = value[7:0];
            CFG_MAX_ID:        cfg_max_id    = value[7:0];
            CFG_ID_POS:        cfg_id_pos    = value[3:0];
            CFG_VALUE_POS:     cfg_value_pos = value[3:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [63:0] hdr, input logic [3:0] len,
                                input logic [7:0] lo, input logic [7:0] hi,
                                input logic [3:0] id_pos, input logic [3:0] value_pos);
        settle();
        write_reg(CFG_HEADER_WORD, hdr);
        write_reg(CFG_HEADER_LENGTH, 64'(len));
        write_reg(CFG_MIN_ID, 64'(lo));
        write_reg(CFG_MAX_ID, 64'(hi));
        write_reg(CFG_ID_POS, 64'(id_pos));
        write_reg(CFG_VALUE_POS, 64'(value_pos));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_config();
        logic [63:0] hdr;
        logic [7:0] b;
        logic [3:0] len;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [3:0] idp;
        logic [3:0] vp;
        hdr = {$urandom, $urandom};
        hdr[7:0] = CH_DOLLAR;
        for (int i = 1; i < 8; i++) begin
            b = hdr[8*i +: 8];
            if (b == CH_COMMA || b == CH_STAR) hdr[8*i +: 8] = b ^ 8'h80;
        end
        case ($urandom_range(0, 9))
            0: len = 4'd0;
            1: len = 4'($urandom_range(9, 15));
            default: len = 4'($urandom_range(1, 8));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            lo = 8'($urandom_range(0, 255));
            hi = 8'($urandom_range(0, 255));
        end
        else begin
            lo = 8'($urandom_range(0, 100));
            hi = 8'($urandom_range(lo, 255));
        end
        idp = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 3));
        vp  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 4));
        apply_config(hdr, len, lo, hi, idp, vp);
    endtask

    // Reset configuration: a one-character header that must be NUL.
    task automatic test_reset_defaults();
        send_text("$,5,7", 1'b1, "", 1'b1);
        send_text("*$,4,-9", 1'b1, "\r\n", 1'b1);
        send_text(",3*00", 1'b0, "", 1'b1);
        send_text("", 1'b0, "", 1'b1);
        send_text("X$,1,2", 1'b1, "", 1'b0);
        send_text("$,0,1", 1'b1, "", 1'b1);
    endtask

    task automatic test_error_codes();
        apply_config(64'h0000_0000_0050_4724, 4'd3, 8'd2, 8'd200, 4'd1, 4'd2);
        send_text("$GP,5,-42", 1'b1, "", 1'b0);
        send_text("$GPS,6,3", 1'b1, "", 1'b0);
        send_text("$GX,5,1", 1'b1, "", 1'b0);
        send_text("$G", 1'b0, "", 1'b0);
        send_text("$GP,5,1", 1'b0, "", 1'b0);
        send_text("$GP,5,1*0", 1'b0, "", 1'b0);
        send_text("$GP,5,1*g1", 1'b0, "", 1'b0);
        send_text("$GP,5,1*00", 1'b0, "", 1'b0);
        send_text("$GP,201,1", 1'b1, "", 1'b0);
        send_text("$GP,-3,1", 1'b1, "", 1'b0);
        send_text("$GP,1,1", 1'b1, "", 1'b0);
        send_text("$GP,999,1", 1'b1, "", 1'b0);
        send_text("$GP,200,1", 1'b1, "", 1'b0);
        send_text("$GP,2,1", 1'b1, "", 1'b0);
    endtask

    task automatic test_number_fields();
        apply_config(64'h0000_0000_0050_4724, 4'd3, 8'd0, 8'd255, 4'd2, 4'd4);
        send_text("$GP,x,7,y, \t+17", 1'b1, "", 1'b0);
        send_text("$GP,,8,,-2147483648", 1'b1, "", 1'b0);
        send_text("$GP,,8,,2147483648", 1'b1, "", 1'b0);
        send_text("$GP,,8,,-99999999999", 1'b1, "", 1'b0);
        send_text("$GP,,8,,12ab,34", 1'b1, "", 1'b0);
        send_text("$GP,,8,", 1'b1, "", 1'b0);
        send_text("$GP,,8,,", 1'b1, "", 1'b0);
        send_text("$GP,,++8,,3", 1'b1, "", 1'b0);
        send_text("$GP,,8,,-", 1'b1, "", 1'b0);
    endtask

    task automatic test_config_extremes();
        // Header length above the header size, identifier field off, value field last.
        apply_config(64'hFEDC_BA98_7654_3224, 4'd15, 8'd0, 8'd255, 4'd0, 4'd15);
        repeat (2) send_random_sentence();
        // Zero header length always matches; value field off.
        apply_config(64'h0, 4'd0, 8'd255, 8'd255, 4'd15, 4'd0);
        repeat (2) send_random_sentence();
        // Empty identifier range, identifier and value share a field.
        apply_config(64'h4443_4241_4D43_5024, 4'd8, 8'd200, 8'd100, 4'd3, 4'd3);
        repeat (2) send_random_sentence();
        apply_config(64'hFFFF_FFFF_FFFF_FF24, 4'd1, 8'd0, 8'd0, 4'd2, 4'd1);
        repeat (2) send_random_sentence();
    endtask

    task automatic test_random_traffic();
        int target;
        int phase_end;
        target = bytes_sent + 80;
        while (bytes_sent < target) begin
            random_config();
            tx_idle = $urandom_range(0, 1);
            rx_idle = $urandom_range(0, 1);
            phase_end = bytes_sent + $urandom_range(20, 40);
            while (bytes_sent < phase_end) send_random_sentence();
        end
    endtask

    // The receiver holds off while the sender keeps offering sentences.
    task automatic test_backpressure();
        random_config();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_cycles = 250;
        repeat (6) send_random_sentence();
    endtask

    task automatic test_steady_stream();
        int target;
        random_config();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        target = bytes_sent + 50;
        while (bytes_sent < target) send_random_sentence();
    endtask

    always @(posedge clk)
    begin
        sentence_status_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (awaited_status.size() == 0) begin
                $error("status item with none awaited: %h", m_tdata);
                mismatches++;
            end
            else begin
                want = awaited_status.pop_front();
                if (m_tdata[0] !== want.ok) begin
                    $error("sentence_ok: expected %0d, got %0d", want.ok, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[3:1] !== want.code) begin
                    $error("error_code: expected %0d, got %0d", want.code, m_tdata[3:1]);
                    mismatches++;
                end
                if (m_tdata[11:4] !== want.id) begin
                    $error("cmd_id: expected %0d, got %0d", want.id, m_tdata[11:4]);
                    mismatches++;
                end
                if (m_tdata[43:12] !== want.value) begin
                    $error("cmd_value: expected %h, got %h", want.value, m_tdata[43:12]);
                    mismatches++;
                end
                if (m_tdata[59:44] !== want.good_cnt) begin
                    $error("valid_count: expected %0d, got %0d", want.good_cnt, m_tdata[59:44]);
                    mismatches++;
                end
                if (m_tdata[75:60] !== want.bad_cnt) begin
                    $error("invalid_count: expected %0d, got %0d", want.bad_cnt, m_tdata[75:60]);
                    mismatches++;
                end
            end
        end

        if (hold_cycles > 0) begin
            hold_cycles--;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (rx_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            m_tready <= 1'b0;
        end
        else begin
            m_tready <= 1'b1;
        end
    end

    initial
    begin
        clear_sentence_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_error_codes();
        test_number_fields();
        test_config_extremes();
        test_random_traffic();
        test_backpressure();
        test_steady_stream();

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ncsc_pkg.sv
rtl/core/nmea_command_sentence_checker.sv
bench/testbench.sv
